/* rtl/cbpq_pkg.sv */
package cbpq_pkg;

  localparam int unsigned DestWidth  = 11;
  localparam int unsigned SizeWidth  = 10;
  localparam int unsigned ColorWidth = 16;
  localparam int unsigned CodeWidth  = 4;
  localparam int unsigned CoordWidth = 8;
  localparam int unsigned AddrWidth  = 5;
  localparam int unsigned DataWidth  = 32;

  // Register map, word index taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SOURCE_WIDTH  = 3'd2,
    REG_SOURCE_HEIGHT = 3'd3,
    REG_SOURCE_COL    = 3'd4,
    REG_SOURCE_ROW    = 3'd5,
    REG_WINDOW_WIDTH  = 3'd6,
    REG_WINDOW_HEIGHT = 3'd7
  } cbpq_reg_e;

  typedef struct packed {
    logic signed [DestWidth-1:0] dest_x;
    logic signed [DestWidth-1:0] dest_y;
    logic [SizeWidth-1:0]        source_width;
    logic [SizeWidth-1:0]        source_height;
    logic [SizeWidth-1:0]        source_col_offset;
    logic [SizeWidth-1:0]        source_row_offset;
    logic [SizeWidth-1:0]        window_width;
    logic [SizeWidth-1:0]        window_height;
  } cbpq_cfg_t;

  // Palette codes
  localparam logic [CodeWidth-1:0] PalBlack   = 4'd0;
  localparam logic [CodeWidth-1:0] PalWhite   = 4'd1;
  localparam logic [CodeWidth-1:0] PalRed     = 4'd2;
  localparam logic [CodeWidth-1:0] PalGreen   = 4'd3;
  localparam logic [CodeWidth-1:0] PalYellow  = 4'd6;
  localparam logic [CodeWidth-1:0] PalMagenta = 4'd7;
  localparam logic [CodeWidth-1:0] PalGrey    = 4'd9;
  localparam logic [CodeWidth-1:0] PalDefault = 4'd13;
  localparam logic [CodeWidth-1:0] PalCyan    = 4'd14;

  // Priority chain of threshold tests on the RGB565 fields
  function automatic logic [CodeWidth-1:0] quantize(input logic [ColorWidth-1:0] color);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    logic [CodeWidth-1:0] code;
    r = color[15:11];
    g = color[10:5];
    b = color[4:0];
    if (r < 5'd3 && g < 6'd6 && b < 5'd3) begin
      code = PalBlack;
    end else if (r > 5'd26 && g > 6'd54 && b > 5'd26) begin
      code = PalWhite;
    end else if (r > 5'd20 && g > 6'd38 && b < 5'd12) begin
      code = PalYellow;
    end else if (r > 5'd18 && g < 6'd20 && b < 5'd12) begin
      code = PalRed;
    end else if (r < 5'd12 && g > 6'd28 && b < 5'd14) begin
      code = PalGreen;
    end else if (r < 5'd12 && g > 6'd30 && b > 5'd18) begin
      code = PalCyan;
    end else if (r > 5'd18 && g < 6'd24 && b > 5'd16) begin
      code = PalMagenta;
    end else if (r > 5'd12 && g > 6'd22 && b > 5'd12) begin
      code = PalGrey;
    end else begin
      code = PalDefault;
    end
    return code;
  endfunction

endpackage

/* rtl/clipped_blit_palette_quantize.sv */
// Channel  | Direction | Handshake                       | Payload
// ---------+-----------+---------------------------------+------------------------------------
// pixel    | in        | pixel_valid_i / pixel_ready_o   | pixel_color_i
// result   | out       | result_valid_o / result_ready_i | screen_x_o, screen_y_o,
//          |           |                                 | palette_code_o, write_enable_o,
//          |           |                                 | window_done_o
// config   | in        | psel, penable, pwrite / pready  | paddr, pwdata, prdata
//
// One request per cycle sustained while the result channel is not stalled; the input register
// takes the pixel, then the result register takes its result.
// Reset clears the window counters, both stage valids and the configuration to its
// reset values (offsets and destination zero, every size one).
// A stalled result holds in the result register while the input register still
// takes one more request; the pixel channel stalls only once both are full.
module clipped_blit_palette_quantize #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cbpq_pkg::AddrWidth-1:0]     paddr,
  input  logic [cbpq_pkg::DataWidth-1:0]     pwdata,
  output logic [cbpq_pkg::DataWidth-1:0]     prdata,
  output logic                               pready,
  // Pixel stream
  input  logic                               pixel_valid_i,
  output logic                               pixel_ready_o,
  input  logic [cbpq_pkg::ColorWidth-1:0]    pixel_color_i,
  // Result stream
  output logic                               result_valid_o,
  input  logic                               result_ready_i,
  output logic [cbpq_pkg::CoordWidth-1:0]    screen_x_o,
  output logic [cbpq_pkg::CoordWidth-1:0]    screen_y_o,
  output logic [cbpq_pkg::CodeWidth-1:0]     palette_code_o,
  output logic                               write_enable_o,
  output logic                               window_done_o
);
  import cbpq_pkg::*;

  cbpq_cfg_t cfg;

  // Register file: size registers reject a zero write and keep their value
  cbpq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Counters, clipping and quantising between input and result registers.
  // The user must keep the configuration static while requests are in flight (the block
  // does not enforce it), since the clip stage reads it straight from the register file.
  cbpq_pipe #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_color_i  (pixel_color_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .palette_code_o (palette_code_o),
    .write_enable_o (write_enable_o),
    .window_done_o  (window_done_o)
  );

endmodule

/* rtl/cbpq_cfg.sv */
module cbpq_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [cbpq_pkg::AddrWidth-1:0]   paddr,
  input  logic [cbpq_pkg::DataWidth-1:0]   pwdata,
  output logic [cbpq_pkg::DataWidth-1:0]   prdata,
  output logic                             pready,
  output cbpq_pkg::cbpq_cfg_t              cfg_o
);
  import cbpq_pkg::*;

  cbpq_cfg_t cfg_q, cfg_d;
  cbpq_reg_e reg_sel;
  logic      wr_en;
  logic [SizeWidth-1:0] wr_size;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cbpq_reg_e'(paddr[4:2]);
  assign wr_size = pwdata[SizeWidth-1:0];

  // Size registers drop a write of zero
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_DEST_X:        cfg_d.dest_x = $signed(pwdata[DestWidth-1:0]);
        REG_DEST_Y:        cfg_d.dest_y = $signed(pwdata[DestWidth-1:0]);
        REG_SOURCE_WIDTH:  if (wr_size != '0) cfg_d.source_width = wr_size;
        REG_SOURCE_HEIGHT: if (wr_size != '0) cfg_d.source_height = wr_size;
        REG_SOURCE_COL:    cfg_d.source_col_offset = wr_size;
        REG_SOURCE_ROW:    cfg_d.source_row_offset = wr_size;
        REG_WINDOW_WIDTH:  if (wr_size != '0) cfg_d.window_width = wr_size;
        REG_WINDOW_HEIGHT: if (wr_size != '0) cfg_d.window_height = wr_size;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dest_x            <= '0;
      cfg_q.dest_y            <= '0;
      cfg_q.source_width      <= SizeWidth'(1);
      cfg_q.source_height     <= SizeWidth'(1);
      cfg_q.source_col_offset <= '0;
      cfg_q.source_row_offset <= '0;
      cfg_q.window_width      <= SizeWidth'(1);
      cfg_q.window_height     <= SizeWidth'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_DEST_X:        prdata = DataWidth'(unsigned'(cfg_q.dest_x));
      REG_DEST_Y:        prdata = DataWidth'(unsigned'(cfg_q.dest_y));
      REG_SOURCE_WIDTH:  prdata = DataWidth'(cfg_q.source_width);
      REG_SOURCE_HEIGHT: prdata = DataWidth'(cfg_q.source_height);
      REG_SOURCE_COL:    prdata = DataWidth'(cfg_q.source_col_offset);
      REG_SOURCE_ROW:    prdata = DataWidth'(cfg_q.source_row_offset);
      REG_WINDOW_WIDTH:  prdata = DataWidth'(cfg_q.window_width);
      REG_WINDOW_HEIGHT: prdata = DataWidth'(cfg_q.window_height);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/cbpq_pipe.sv */
module cbpq_pipe #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  cbpq_pkg::cbpq_cfg_t                cfg_i,
  input  logic                               pixel_valid_i,
  output logic                               pixel_ready_o,
  input  logic [cbpq_pkg::ColorWidth-1:0]    pixel_color_i,
  output logic                               result_valid_o,
  input  logic                               result_ready_i,
  output logic [cbpq_pkg::CoordWidth-1:0]    screen_x_o,
  output logic [cbpq_pkg::CoordWidth-1:0]    screen_y_o,
  output logic [cbpq_pkg::CodeWidth-1:0]     palette_code_o,
  output logic                               write_enable_o,
  output logic                               window_done_o
);
  import cbpq_pkg::*;

  localparam logic [SizeWidth:0] ScrWidth  = (SizeWidth + 1)'(SCREEN_WIDTH);
  localparam logic [SizeWidth:0] ScrHeight = (SizeWidth + 1)'(SCREEN_HEIGHT);

  // Window counters
  logic [SizeWidth-1:0] col_q, col_d, row_q, row_d;
  logic [SizeWidth:0]   col_inc, row_inc;
  logic                 row_end, win_end;

  // Input register
  logic                  in_valid_q, in_valid_d;
  logic [ColorWidth-1:0] in_color_q;
  logic [SizeWidth-1:0]  in_col_q, in_row_q;
  logic                  in_done_q;

  // Result register
  logic                  out_valid_q, out_valid_d;
  logic [CoordWidth-1:0] out_x_q, out_y_q;
  logic [CodeWidth-1:0]  out_code_q;
  logic                  out_we_q, out_done_q;

  logic accept, out_free, move;

  // Clip logic
  logic [SizeWidth:0]   src_x, src_y;
  logic [DestWidth:0]   dst_x, dst_y;
  logic                 in_src, in_scr, wr_en;

  assign out_free      = !out_valid_q || result_ready_i;
  assign move          = in_valid_q && out_free;
  assign pixel_ready_o = !in_valid_q || out_free;
  assign accept        = pixel_valid_i && pixel_ready_o;

  assign col_inc = {1'b0, col_q} + 1'b1;
  assign row_inc = {1'b0, row_q} + 1'b1;
  assign row_end = col_inc >= {1'b0, cfg_i.window_width};
  assign win_end = row_end && (row_inc >= {1'b0, cfg_i.window_height});

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (win_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_inc[SizeWidth-1:0];
      end else begin
        col_d = col_inc[SizeWidth-1:0];
      end
    end
  end

  assign in_valid_d  = accept ? 1'b1 : (out_free ? 1'b0 : in_valid_q);
  assign out_valid_d = out_free ? in_valid_q : out_valid_q;

  assign src_x = {1'b0, cfg_i.source_col_offset} + {1'b0, in_col_q};
  assign src_y = {1'b0, cfg_i.source_row_offset} + {1'b0, in_row_q};
  assign dst_x = {cfg_i.dest_x[DestWidth-1], cfg_i.dest_x} + {2'b00, in_col_q};
  assign dst_y = {cfg_i.dest_y[DestWidth-1], cfg_i.dest_y} + {2'b00, in_row_q};

  assign in_src = (src_x < {1'b0, cfg_i.source_width}) &&
                  (src_y < {1'b0, cfg_i.source_height});
  assign in_scr = !dst_x[DestWidth] && (dst_x[DestWidth-1:0] < ScrWidth) &&
                  !dst_y[DestWidth] && (dst_y[DestWidth-1:0] < ScrHeight);
  assign wr_en  = in_src && in_scr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q       <= col_d;
      row_q       <= row_d;
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_color_q <= pixel_color_i;
      in_col_q   <= col_q;
      in_row_q   <= row_q;
      in_done_q  <= win_end;
    end
    if (move) begin
      out_x_q    <= wr_en ? dst_x[CoordWidth-1:0] : '0;
      out_y_q    <= wr_en ? dst_y[CoordWidth-1:0] : '0;
      out_code_q <= quantize(in_color_q);
      out_we_q   <= wr_en;
      out_done_q <= in_done_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign screen_x_o     = out_x_q;
  assign screen_y_o     = out_y_q;
  assign palette_code_o = out_code_q;
  assign write_enable_o = out_we_q;
  assign window_done_o  = out_done_q;

endmodule

/* rtl/cbpq_checker.sv */
module cbpq_checker #(
  parameter int unsigned SCREEN_WIDTH  = 240,
  parameter int unsigned SCREEN_HEIGHT = 240
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       pixel_valid_i,
  input logic       pixel_ready_o,
  input logic       result_valid_o,
  input logic       result_ready_i,
  input logic [7:0] screen_x_o,
  input logic [7:0] screen_y_o,
  input logic [3:0] palette_code_o,
  input logic       write_enable_o,
  input logic       window_done_o
);

  localparam logic [10:0] ScrWidth  = 11'(SCREEN_WIDTH);
  localparam logic [10:0] ScrHeight = 11'(SCREEN_HEIGHT);

  logic [1:0] inflight_q, inflight_d;
  logic       in_acc, out_acc;

  assign in_acc  = pixel_valid_i && pixel_ready_o;
  assign out_acc = result_valid_o && result_ready_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // Stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_ready_i |=> result_valid_o && $stable(screen_x_o) &&
      $stable(screen_y_o) && $stable(palette_code_o) && $stable(write_enable_o) &&
      $stable(window_done_o))
    else $error("result changed while stalled");

  // Never more requests held than the two stage registers
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == 2'd2) && !result_ready_i |-> !pixel_ready_o)
    else $error("pixel taken with both stages full");

  // No result without a request behind it
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> inflight_q != 2'd0)
    else $error("result without accepted pixel");

  // Clipped pixels show zero coordinates, written ones lie on screen
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (!write_enable_o && screen_x_o == 8'd0 && screen_y_o == 8'd0) ||
      (write_enable_o && ({3'b000, screen_x_o} < ScrWidth || ScrWidth > 11'd256) &&
       ({3'b000, screen_y_o} < ScrHeight || ScrHeight > 11'd256)))
    else $error("coordinates inconsistent with write flag");

endmodule

bind clipped_blit_palette_quantize cbpq_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_cbpq_checker (.*);

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbpq_pkg::*;

  localparam int ScreenW      = 240;
  localparam int ScreenH      = 240;
  localparam int MaxGap       = 14;
  localparam int RandomPixels = 700;
  localparam int PrintCap     = 100;

  // One expected screen placement, field for field as the result channel carries it
  typedef struct packed {
    logic [CoordWidth-1:0] screen_x;
    logic [CoordWidth-1:0] screen_y;
    logic [CodeWidth-1:0]  code;
    logic                  write_en;
    logic                  last;
  } placement_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [AddrWidth-1:0]  paddr          = '0;
  logic [DataWidth-1:0]  pwdata         = '0;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;
  logic                  pixel_valid_i  = 1'b0;
  logic                  pixel_ready_o;
  logic [ColorWidth-1:0] pixel_color_i  = '0;
  logic                  result_valid_o;
  logic                  result_ready_i = 1'b0;
  logic [CoordWidth-1:0] screen_x_o;
  logic [CoordWidth-1:0] screen_y_o;
  logic [CodeWidth-1:0]  palette_code_o;
  logic                  write_enable_o;
  logic                  window_done_o;

  // Shadow of the register file and of the window counters
  cbpq_cfg_t            model_cfg;
  logic [SizeWidth-1:0] model_row;
  logic [SizeWidth-1:0] model_col;
  placement_t           expected_placements[$];

  int errors    = 0;
  int send_mode = 0;
  int recv_mode = 0;

  const cbpq_reg_e all_regs[8] = '{REG_DEST_X, REG_DEST_Y, REG_SOURCE_WIDTH,
                                   REG_SOURCE_HEIGHT, REG_SOURCE_COL, REG_SOURCE_ROW,
                                   REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT};

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  clipped_blit_palette_quantize #(
    .SCREEN_WIDTH (ScreenW),
    .SCREEN_HEIGHT(ScreenH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_color_i (pixel_color_i),
    .result_valid_o(result_valid_o),
    .result_ready_i(result_ready_i),
    .screen_x_o    (screen_x_o),
    .screen_y_o    (screen_y_o),
    .palette_code_o(palette_code_o),
    .write_enable_o(write_enable_o),
    .window_done_o (window_done_o)
  );

  // Priority chain: the first threshold test that matches wins
  function automatic logic [CodeWidth-1:0] palette_of(logic [ColorWidth-1:0] color);
    int r;
    int g;
    int b;
    r = color[15:11];
    g = color[10:5];
    b = color[4:0];
    if (r < 3 && g < 6 && b < 3)        return PalBlack;
    if (r > 26 && g > 54 && b > 26)     return PalWhite;
    if (r > 20 && g > 38 && b < 12)     return PalYellow;
    if (r > 18 && g < 20 && b < 12)     return PalRed;
    if (r < 12 && g > 28 && b < 14)     return PalGreen;
    if (r < 12 && g > 30 && b > 18)     return PalCyan;
    if (r > 18 && g < 24 && b > 16)     return PalMagenta;
    if (r > 12 && g > 22 && b > 12)     return PalGrey;
    return PalDefault;
  endfunction

  // Place one accepted pixel on the screen and advance the window counters
  function automatic placement_t place_pixel(logic [ColorWidth-1:0] color);
    int         sx;
    int         sy;
    int         dx;
    int         dy;
    bit         visible;
    bit         row_end;
    bit         window_end;
    placement_t p;
    sx = int'(model_cfg.source_col_offset) + int'(model_col);
    sy = int'(model_cfg.source_row_offset) + int'(model_row);
    dx = $signed(model_cfg.dest_x);
    dy = $signed(model_cfg.dest_y);
    dx = dx + int'(model_col);
    dy = dy + int'(model_row);
    visible = sx < int'(model_cfg.source_width) && sy < int'(model_cfg.source_height) &&
              dx >= 0 && dx < ScreenW && dy >= 0 && dy < ScreenH;
    // A counter at or past the last column/row ends it, so a shrunk window closes early
    row_end    = int'(model_col) + 1 >= int'(model_cfg.window_width);
    window_end = row_end && int'(model_row) + 1 >= int'(model_cfg.window_height);
    // Clipped pixels report the origin but still carry their palette code
    p.screen_x = visible ? 8'(dx) : '0;
    p.screen_y = visible ? 8'(dy) : '0;
    p.code     = palette_of(color);
    p.write_en = visible;
    p.last     = window_end;
    if (window_end) begin
      model_row = '0;
      model_col = '0;
    end else if (row_end) begin
      model_col = '0;
      model_row = model_row + 1'b1;
    end else begin
      model_col = model_col + 1'b1;
    end
    return p;
  endfunction

  // Mode 0: no idling, mode 1: full range, otherwise: mostly back to back
  function automatic int draw_gap(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, MaxGap);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MaxGap) : 0;
  endfunction

  function automatic logic [ColorWidth-1:0] rgb565(int r, int g, int b);
    return {5'(r), 6'(g), 5'(b)};
  endfunction

  // Random register value; upper pwdata bits are noise the block must drop
  function automatic logic [DataWidth-1:0] draw_reg_value(cbpq_reg_e idx);
    int v;
    case (idx)
      REG_DEST_X, REG_DEST_Y: begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 1023 : -1024;
        else v = int'($urandom_range(0, 266)) - 16;
        return ($urandom & ~32'h7FF) | (32'(v) & 32'h7FF);
      end
      REG_SOURCE_COL, REG_SOURCE_ROW: begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 1023 : 0;
        else v = $urandom_range(0, 20);
      end
      REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT: begin
        if ($urandom_range(0, 9) == 0) v = 0;
        else if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 1) ? 1023 : 1;
        else v = $urandom_range(1, 40);
      end
      default: begin
        if ($urandom_range(0, 9) == 0) v = 0;
        else if ($urandom_range(0, 9) == 0) v = 1023;
        else v = $urandom_range(1, 12);
      end
    endcase
    return ($urandom & ~32'h3FF) | (32'(v) & 32'h3FF);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= PrintCap) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // APB write: setup cycle, then access cycle; mirror the write once it lands
  task automatic cfg_write(cbpq_reg_e idx, logic [DataWidth-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Size registers reject zero; signed registers take any 11-bit pattern
    case (idx)
      REG_DEST_X:        model_cfg.dest_x = data[DestWidth-1:0];
      REG_DEST_Y:        model_cfg.dest_y = data[DestWidth-1:0];
      REG_SOURCE_WIDTH:  if (data[SizeWidth-1:0] != '0) model_cfg.source_width  = data[9:0];
      REG_SOURCE_HEIGHT: if (data[SizeWidth-1:0] != '0) model_cfg.source_height = data[9:0];
      REG_SOURCE_COL:    model_cfg.source_col_offset = data[SizeWidth-1:0];
      REG_SOURCE_ROW:    model_cfg.source_row_offset = data[SizeWidth-1:0];
      REG_WINDOW_WIDTH:  if (data[SizeWidth-1:0] != '0) model_cfg.window_width  = data[9:0];
      REG_WINDOW_HEIGHT: if (data[SizeWidth-1:0] != '0) model_cfg.window_height = data[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one pixel request after a drawn gap and hold it until accepted
  task automatic send_pixel(logic [ColorWidth-1:0] color);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      @(negedge clk_i);
      pixel_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pixel_valid_i <= 1'b1;
    pixel_color_i <= color;
    do @(posedge clk_i); while (!pixel_ready_o);
    expected_placements.push_back(place_pixel(color));
  endtask

  // Drop valid and wait until every placement is back, then let the pipeline settle
  task automatic drain_pipeline();
    @(negedge clk_i);
    pixel_valid_i <= 1'b0;
    while (expected_placements.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_reset_defaults();
    // A 1x1 window at the origin: every pixel is written and ends the window
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    drain_pipeline();
  endtask

  task automatic test_palette_chain();
    send_mode = 1;
    recv_mode = 1;
    send_pixel(rgb565(2, 5, 2));     // black, on the edge
    send_pixel(rgb565(31, 63, 31));  // white
    send_pixel(rgb565(21, 39, 11));  // yellow
    send_pixel(rgb565(19, 19, 11));  // red
    send_pixel(rgb565(11, 29, 13));  // green
    send_pixel(rgb565(11, 31, 19));  // cyan
    send_pixel(rgb565(19, 23, 17));  // magenta
    send_pixel(rgb565(13, 23, 13));  // grey
    send_pixel(rgb565(3, 0, 0));     // falls through to the default
    drain_pipeline();
  endtask

  task automatic test_full_bitmap();
    // Offsets zero and source size equal to the window
    send_mode = 0;
    recv_mode = 0;
    cfg_write(REG_DEST_X, 32'd10);
    cfg_write(REG_DEST_Y, 32'd20);
    cfg_write(REG_SOURCE_WIDTH, 32'd2);
    cfg_write(REG_SOURCE_HEIGHT, 32'd2);
    cfg_write(REG_WINDOW_WIDTH, 32'd2);
    cfg_write(REG_WINDOW_HEIGHT, 32'd2);
    repeat (4) send_pixel(16'($urandom));
    drain_pipeline();
  endtask

  task automatic test_clipping();
    // Straddle the left and bottom screen edges
    send_mode = 2;
    recv_mode = 2;
    cfg_write(REG_DEST_X, 32'(-1));
    cfg_write(REG_DEST_Y, 32'd239);
    cfg_write(REG_SOURCE_WIDTH, 32'd1023);
    cfg_write(REG_SOURCE_HEIGHT, 32'd1023);
    repeat (4) send_pixel(16'($urandom));
    drain_pipeline();
    // Destination and offsets at their extremes, outside the source entirely
    cfg_write(REG_DEST_X, 32'd1023);
    cfg_write(REG_DEST_Y, 32'(-1024));
    cfg_write(REG_SOURCE_WIDTH, 32'd1);
    cfg_write(REG_SOURCE_COL, 32'd1023);
    cfg_write(REG_SOURCE_ROW, 32'd1023);
    cfg_write(REG_WINDOW_WIDTH, 32'd1);
    cfg_write(REG_WINDOW_HEIGHT, 32'd1);
    send_pixel(16'($urandom));
    drain_pipeline();
  endtask

  task automatic test_rejected_writes();
    cfg_write(REG_DEST_X, 32'd0);
    cfg_write(REG_DEST_Y, 32'd0);
    cfg_write(REG_SOURCE_COL, 32'd0);
    cfg_write(REG_SOURCE_ROW, 32'd0);
    cfg_write(REG_SOURCE_WIDTH, 32'd4);
    cfg_write(REG_SOURCE_HEIGHT, 32'd4);
    cfg_write(REG_WINDOW_WIDTH, 32'd2);
    cfg_write(REG_WINDOW_HEIGHT, 32'd1);
    // Zero sizes must bounce off, including a zero hidden under set upper bits
    cfg_write(REG_WINDOW_WIDTH, 32'd0);
    cfg_write(REG_WINDOW_HEIGHT, 32'h0000_0400);
    cfg_write(REG_SOURCE_WIDTH, 32'd0);
    cfg_write(REG_SOURCE_HEIGHT, 32'hFFFF_FC00);
    repeat (2) send_pixel(16'($urandom));
    drain_pipeline();
  endtask

  task automatic test_window_shrink();
    cfg_write(REG_WINDOW_WIDTH, 32'd4);
    cfg_write(REG_WINDOW_HEIGHT, 32'd3);
    repeat (5) send_pixel(16'($urandom));
    drain_pipeline();
    // Counters now sit past the new last column and row: the next pixel ends the window
    cfg_write(REG_WINDOW_WIDTH, 32'd1);
    cfg_write(REG_WINDOW_HEIGHT, 32'd1);
    send_pixel(16'($urandom));
    drain_pipeline();
  endtask

  task automatic test_random_windows();
    int sent;
    int count;
    int ww;
    int wh;
    int remaining;
    sent = 0;
    while (sent < RandomPixels) begin
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      foreach (all_regs[i]) begin
        if ($urandom_range(0, 3) != 0) cfg_write(all_regs[i], draw_reg_value(all_regs[i]));
      end
      ww = model_cfg.window_width;
      wh = model_cfg.window_height;
      if (int'(model_row) < wh && int'(model_col) < ww) begin
        remaining = (wh - int'(model_row) - 1) * ww + (ww - int'(model_col));
      end else begin
        remaining = 1;
      end
      // Mostly finish the current window and run whole ones; else stop mid-window
      if ($urandom_range(0, 3) != 0 && ww * wh <= 150) begin
        count = remaining + ww * wh * $urandom_range(0, 2);
      end else begin
        count = $urandom_range(1, 30);
      end
      repeat (count) send_pixel(16'($urandom));
      sent += count;
      drain_pipeline();
    end
  endtask

  // Result side: draw a stall per result, then compare with the oldest placement
  initial begin : result_monitor
    int         gap;
    int         seen;
    placement_t got;
    placement_t want;
    seen = 0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        @(negedge clk_i);
        result_ready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      result_ready_i <= 1'b1;
      do @(posedge clk_i); while (!result_valid_o);
      got = '{screen_x_o, screen_y_o, palette_code_o, write_enable_o, window_done_o};
      if (expected_placements.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", seen));
      end else begin
        want = expected_placements.pop_front();
        if (got.screen_x !== want.screen_x)
          report_mismatch($sformatf("result %0d screen_x %0d, want %0d", seen,
                                    got.screen_x, want.screen_x));
        if (got.screen_y !== want.screen_y)
          report_mismatch($sformatf("result %0d screen_y %0d, want %0d", seen,
                                    got.screen_y, want.screen_y));
        if (got.code !== want.code)
          report_mismatch($sformatf("result %0d palette_code %0d, want %0d", seen,
                                    got.code, want.code));
        if (got.write_en !== want.write_en)
          report_mismatch($sformatf("result %0d write_enable %0b, want %0b", seen,
                                    got.write_en, want.write_en));
        if (got.last !== want.last)
          report_mismatch($sformatf("result %0d window_done %0b, want %0b", seen,
                                    got.last, want.last));
      end
      seen++;
    end
  end

  // Hard limit, well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    model_cfg.dest_x            = '0;
    model_cfg.dest_y            = '0;
    model_cfg.source_width      = 10'd1;
    model_cfg.source_height     = 10'd1;
    model_cfg.source_col_offset = '0;
    model_cfg.source_row_offset = '0;
    model_cfg.window_width      = 10'd1;
    model_cfg.window_height     = 10'd1;
    model_row                   = '0;
    model_col                   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_palette_chain();
    test_full_bitmap();
    test_clipping();
    test_rejected_writes();
    test_window_shrink();
    test_random_windows();

    // Catch any stray result after the last placement has come back
    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
